@@ hdl/tile_dedup_with_flips_macros.svh @@
// Assertion macros for the tile deduplication block.
// Included by any module that carries concurrent checks; needs clk_i and rst_ni in scope.
`ifndef TILE_DEDUP_WITH_FLIPS_MACROS_SVH
`define TILE_DEDUP_WITH_FLIPS_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TDF_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

@@ hdl/tdf_pkg.sv @@
// Shared types, constants and orientation functions for the tile deduplication block.
// No dependencies.
package tdf_pkg;

  localparam int unsigned PLANE_W = 64;
  localparam int unsigned TILE_W  = 2 * PLANE_W;
  localparam int unsigned CNT_W   = 9;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned NUM_ORIENT = 4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic emit_err;
    logic scan_init;
    logic issue;
    logic emit_hit;
    logic finish;
  } tdf_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic err;
    logic more;
    logic cmp_vld;
    logic hit;
  } tdf_sts_t;

  // Reverse the bit order inside every row byte of one plane.
  function automatic logic [PLANE_W-1:0] mirror_rows(input logic [PLANE_W-1:0] x);
    logic [PLANE_W-1:0] y;
    y = '0;
    for (int r = 0; r < 8; r++) begin
      for (int b = 0; b < 8; b++) begin
        y[8*r + b] = x[8*r + (7 - b)];
      end
    end
    return y;
  endfunction

  // Reverse the order of the row bytes of one plane.
  function automatic logic [PLANE_W-1:0] reverse_rows(input logic [PLANE_W-1:0] x);
    logic [PLANE_W-1:0] y;
    y = '0;
    for (int r = 0; r < 8; r++) begin
      y[8*(7 - r) +: 8] = x[8*r +: 8];
    end
    return y;
  endfunction

  // Orient both planes of a tile; each flip is its own inverse.
  function automatic logic [TILE_W-1:0] orient_tile(input logic [TILE_W-1:0] t,
                                                     input logic fh, input logic fv);
    logic [PLANE_W-1:0] p0;
    logic [PLANE_W-1:0] p1;
    p0 = t[PLANE_W-1:0];
    p1 = t[TILE_W-1:PLANE_W];
    if (fh) begin
      p0 = mirror_rows(p0);
      p1 = mirror_rows(p1);
    end
    if (fv) begin
      p0 = reverse_rows(p0);
      p1 = reverse_rows(p1);
    end
    return {p1, p0};
  endfunction

endpackage

@@ hdl/tile_dedup_with_flips.sv @@
// Top level of the tile deduplication block with mirror detection.
// Depends on tdf_pkg, tdf_ctrl, tdf_dp and tdf_ram; assertions from the macro header.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  request   | start, busy (accept: start | plane0_rows_i, plane1_rows_i, start_run_i
//            | high while busy is low)    |
//  result    | done_o (one-cycle strobe)  | tile_index_o, mirror_horizontal_o,
//            |                            | mirror_vertical_o, is_new_o, status_o
//
// A request scans the stored entries in order and stops at the first hit; a miss on an
// empty table reads nothing, and a request that meets a sticky error gets its result
// without a scan. The single table read port reads one entry a cycle, with all four
// orientations compared at once. busy falls at the edge that raises done_o.
// Reset empties the table and clears the error; no clearing pass runs. The result side
// cannot stall: each result is shown for exactly one cycle.
`include "tile_dedup_with_flips_macros.svh"

module tile_dedup_with_flips
  import tdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [PLANE_W-1:0] plane0_rows_i,
  input  logic [PLANE_W-1:0] plane1_rows_i,
  input  logic               start_run_i,
  output logic               done_o,
  output logic [IDX_W-1:0]   tile_index_o,
  output logic               mirror_horizontal_o,
  output logic               mirror_vertical_o,
  output logic               is_new_o,
  output logic               status_o
);

  tdf_cmd_t cmd;
  tdf_sts_t sts;

  // Sequence the search
  tdf_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  // Hold the table and compute the result
  tdf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .plane0_rows_i       (plane0_rows_i),
    .plane1_rows_i       (plane1_rows_i),
    .start_run_i         (start_run_i),
    .sts_o               (sts),
    .done_o              (done_o),
    .tile_index_o        (tile_index_o),
    .mirror_horizontal_o (mirror_horizontal_o),
    .mirror_vertical_o   (mirror_vertical_o),
    .is_new_o            (is_new_o),
    .status_o            (status_o)
  );

  // Checks
  `TDF_ASSERT(a_accept_busy, (start && !busy) |=> busy, "busy not raised after accept")
  `TDF_ASSERT(a_done_idle, done_o |-> !busy, "result shown while still busy")
  `TDF_ASSERT(a_done_single, done_o |=> !done_o, "two results for one request")
  `TDF_ASSERT_NEVER(a_err_payload, done_o && status_o && (is_new_o || mirror_horizontal_o
                    || mirror_vertical_o || (tile_index_o != '0)), "error result not zeroed")

endmodule

@@ hdl/tdf_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read ports
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/tdf_ctrl.sv @@
// Controller state machine for the tile deduplication block.
// Depends on tdf_pkg for the command and status structs.
module tdf_ctrl
  import tdf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  tdf_sts_t sts_i,
  output tdf_cmd_t cmd_o,
  output logic     busy_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    busy_d  = busy_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
          busy_d     = 1'b1;
        end
      end
      S_CHECK: begin
        if (sts_i.err) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
          busy_d         = 1'b0;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.hit) begin
          cmd_o.emit_hit = 1'b1;
          state_d        = S_IDLE;
          busy_d         = 1'b0;
        end else if (sts_i.more) begin
          cmd_o.issue = 1'b1;
        end else if (!sts_i.cmp_vld) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
          busy_d       = 1'b0;
        end
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  // Hold state and the busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

@@ hdl/tdf_dp.sv @@
// Datapath of the tile deduplication block: tile targets, table RAM, scan and result.
// Depends on tdf_pkg and tdf_ram.
module tdf_dp
  import tdf_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tdf_cmd_t           cmd_i,
  input  logic [PLANE_W-1:0] plane0_rows_i,
  input  logic [PLANE_W-1:0] plane1_rows_i,
  input  logic               start_run_i,
  output tdf_sts_t           sts_o,
  output logic               done_o,
  output logic [IDX_W-1:0]   tile_index_o,
  output logic               mirror_horizontal_o,
  output logic               mirror_vertical_o,
  output logic               is_new_o,
  output logic               status_o
);

  localparam int unsigned AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned DW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned CW  = (DW > CNT_W) ? DW : CNT_W;

  logic [TILE_W-1:0]     tgt_q [NUM_ORIENT];
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  err_q, err_d;
  logic [CNT_W-1:0]      scan_q, scan_d;
  logic [CNT_W-1:0]      cmp_idx_q, cmp_idx_d;
  logic                  cmp_vld_q, cmp_vld_d;
  logic [TILE_W-1:0]     rd_data;
  logic [NUM_ORIENT-1:0] match;
  logic [CW-1:0]         cnt_ext;
  logic [CW-1:0]         scan_ext;
  logic                  room;
  logic                  we;

  logic                  done_q, done_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  mh_q, mh_d;
  logic                  mv_q, mv_d;
  logic                  new_q, new_d;
  logic                  stat_q, stat_d;

  // Latch the four orientations of the request tile
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int v = 0; v < NUM_ORIENT; v++) begin
        tgt_q[v] <= orient_tile({plane1_rows_i, plane0_rows_i}, v[0], v[1]);
      end
    end
  end

  assign cnt_ext  = CW'(cnt_q);
  assign scan_ext = CW'(scan_q);
  assign room     = cnt_ext < CW'(TABLE_DEPTH);
  assign we       = cmd_i.finish && room;

  // Table of unique tiles, plane 1 in the upper half
  tdf_ram #(
    .WIDTH (TILE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (cnt_ext[AW-1:0]),
    .wdata_i (tgt_q[0]),
    .re_i    (cmd_i.issue),
    .raddr_i (scan_ext[AW-1:0]),
    .rdata_o (rd_data)
  );

  // Compare the stored entry against every orientation
  always_comb begin
    for (int v = 0; v < NUM_ORIENT; v++) begin
      match[v] = (rd_data == tgt_q[v]);
    end
  end

  assign sts_o.err     = err_q;
  assign sts_o.more    = scan_q < cnt_q;
  assign sts_o.cmp_vld = cmp_vld_q;
  assign sts_o.hit     = cmp_vld_q && (|match);

  // Advance table state, scan pointer and result
  always_comb begin
    cnt_d     = cnt_q;
    err_d     = err_q;
    scan_d    = scan_q;
    cmp_idx_d = cmp_idx_q;
    cmp_vld_d = cmd_i.issue;
    done_d    = 1'b0;
    idx_d     = idx_q;
    mh_d      = mh_q;
    mv_d      = mv_q;
    new_d     = new_q;
    stat_d    = stat_q;

    if (cmd_i.load && start_run_i) begin
      cnt_d = '0;
      err_d = 1'b0;
    end
    if (cmd_i.scan_init) begin
      scan_d = '0;
    end
    if (cmd_i.issue) begin
      cmp_idx_d = scan_q;
      scan_d    = scan_q + 1'b1;
    end
    if (cmd_i.emit_err) begin
      done_d = 1'b1;
      idx_d  = '0;
      mh_d   = 1'b0;
      mv_d   = 1'b0;
      new_d  = 1'b0;
      stat_d = 1'b1;
    end
    if (cmd_i.emit_hit) begin
      done_d = 1'b1;
      idx_d  = cmp_idx_q[IDX_W-1:0];
      new_d  = 1'b0;
      stat_d = 1'b0;
      if (match[0]) begin
        mh_d = 1'b0;
        mv_d = 1'b0;
      end else if (match[1]) begin
        mh_d = 1'b1;
        mv_d = 1'b0;
      end else if (match[2]) begin
        mh_d = 1'b0;
        mv_d = 1'b1;
      end else begin
        mh_d = 1'b1;
        mv_d = 1'b1;
      end
    end
    if (cmd_i.finish) begin
      done_d = 1'b1;
      mh_d   = 1'b0;
      mv_d   = 1'b0;
      if (room) begin
        idx_d  = cnt_q[IDX_W-1:0];
        new_d  = 1'b1;
        stat_d = 1'b0;
        cnt_d  = cnt_q + 1'b1;
      end else begin
        idx_d  = '0;
        new_d  = 1'b0;
        stat_d = 1'b1;
        err_d  = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      err_q     <= 1'b0;
      cmp_vld_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      err_q     <= err_d;
      cmp_vld_q <= cmp_vld_d;
      done_q    <= done_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    scan_q    <= scan_d;
    cmp_idx_q <= cmp_idx_d;
    idx_q     <= idx_d;
    mh_q      <= mh_d;
    mv_q      <= mv_d;
    new_q     <= new_d;
    stat_q    <= stat_d;
  end

  assign done_o              = done_q;
  assign tile_index_o        = idx_q;
  assign mirror_horizontal_o = mh_q;
  assign mirror_vertical_o   = mv_q;
  assign is_new_o            = new_q;
  assign status_o            = stat_q;

endmodule

@@ tb/sv/tile_dedup_with_flips_tb.sv @@
// Self-checking testbench for tile_dedup_with_flips: directed tiles, then random runs.
// Predicts index, mirror flags, new-entry and table-full status per request.
// Depends on tdf_pkg and the tile_dedup_with_flips RTL.
module tile_dedup_with_flips_tb
  import tdf_pkg::*;
();

  localparam int TBL_DEPTH   = 256;
  localparam int RAND_ITEMS  = 1800;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int TAIL_CYCLES = 300;
  localparam int MAX_PRINTS  = 50;

  localparam logic [PLANE_W-1:0] M_ODD  = 64'h5555_5555_5555_5555;
  localparam logic [PLANE_W-1:0] M_PAIR = 64'h3333_3333_3333_3333;
  localparam logic [PLANE_W-1:0] M_NIB  = 64'h0F0F_0F0F_0F0F_0F0F;

  typedef struct packed {
    logic [PLANE_W-1:0] p0;
    logic [PLANE_W-1:0] p1;
    logic               run;
    logic               drain;
  } tile_req_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic             mh;
    logic             mv;
    logic             is_new;
    logic             status;
  } tile_res_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic start  = 1'b0;
  logic busy;
  logic done_o;
  logic [IDX_W-1:0] tile_index_o;
  logic mirror_horizontal_o;
  logic mirror_vertical_o;
  logic is_new_o;
  logic status_o;

  tile_req_t drv_req = '0;

  // Requests waiting to be sent and results waiting to arrive
  tile_req_t req_q[$];
  tile_res_t want_q[$];

  // Predicted table contents
  logic [PLANE_W-1:0] tbl_p0 [TBL_DEPTH];
  logic [PLANE_W-1:0] tbl_p1 [TBL_DEPTH];
  int  fill_cnt    = 0;
  bit  sticky_full = 1'b0;

  int n_sent    = 0;
  int n_taken   = 0;
  int n_planned = 0;
  int idle_pct  = 0;
  int err_cnt   = 0;
  int unsigned cyc_cnt = 0;
  tile_res_t want;
  tile_res_t pred;

  tile_dedup_with_flips #(
    .TABLE_DEPTH(TBL_DEPTH)
  ) u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .plane0_rows_i      (drv_req.p0),
    .plane1_rows_i      (drv_req.p1),
    .start_run_i        (drv_req.run),
    .done_o             (done_o),
    .tile_index_o       (tile_index_o),
    .mirror_horizontal_o(mirror_horizontal_o),
    .mirror_vertical_o  (mirror_vertical_o),
    .is_new_o           (is_new_o),
    .status_o           (status_o)
  );

  // Clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Apply an orientation to one plane: h reverses bits within each row byte,
  // v reverses the row order.
  function automatic logic [PLANE_W-1:0] turn_plane(input logic [PLANE_W-1:0] x,
                                                    input logic h, input logic v);
    logic [PLANE_W-1:0] y;
    if (h) begin
      x = ((x >> 1) & M_ODD)  | ((x & M_ODD)  << 1);
      x = ((x >> 2) & M_PAIR) | ((x & M_PAIR) << 2);
      x = ((x >> 4) & M_NIB)  | ((x & M_NIB)  << 4);
    end
    if (v) begin
      y = '0;
      for (int r = 0; r < 8; r++) begin
        y = (y << 8) | {56'b0, x[8*r +: 8]};
      end
      x = y;
    end
    return x;
  endfunction

  // Look the tile up in the predicted table and update it
  task automatic predict_tile(input tile_req_t rq, output tile_res_t rs);
    bit found;
    logic fh;
    logic fv;
    rs = '0;
    found = 1'b0;
    if (rq.run) begin
      fill_cnt = 0;
      sticky_full = 1'b0;
    end
    if (sticky_full) begin
      rs.status = 1'b1;
      return;
    end
    // Scan entries in order; orientation bit 0 is horizontal, bit 1 vertical
    for (int u = 0; u < fill_cnt && !found; u++) begin
      for (int o = 0; o < 4 && !found; o++) begin
        fh = o[0];
        fv = o[1];
        if (turn_plane(tbl_p0[u], fh, fv) == rq.p0 &&
            turn_plane(tbl_p1[u], fh, fv) == rq.p1) begin
          found = 1'b1;
          rs.index = u[IDX_W-1:0];
          rs.mh = fh;
          rs.mv = fv;
        end
      end
    end
    if (found) return;
    if (fill_cnt >= TBL_DEPTH) begin
      sticky_full = 1'b1;
      rs.status = 1'b1;
      return;
    end
    tbl_p0[fill_cnt] = rq.p0;
    tbl_p1[fill_cnt] = rq.p1;
    rs.index = fill_cnt[IDX_W-1:0];
    rs.is_new = 1'b1;
    fill_cnt++;
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp_val);
    if (err_cnt < MAX_PRINTS) begin
      $display("%0t: mismatch on %s: got %0h, want %0h", $realtime, what, got, exp_val);
    end
    err_cnt++;
  endtask

  task automatic queue_tile(input logic [PLANE_W-1:0] a, input logic [PLANE_W-1:0] b,
                            input logic run, input logic drain);
    tile_req_t rq;
    rq.p0 = a;
    rq.p1 = b;
    rq.run = run;
    rq.drain = drain;
    req_q.push_back(rq);
  endtask

  // Drive requests at the falling edge; hold one until it is taken
  always @(negedge clk_i) begin
    if (rst_ni && n_taken == n_sent) begin
      idle_pct = (n_sent < n_planned / 3) ? 24 : (n_sent < 2 * n_planned / 3) ? 54 : 0;
      if (req_q.size() != 0 && !(req_q[0].drain && want_q.size() != 0) &&
          $urandom_range(99) >= idle_pct) begin
        drv_req <= req_q.pop_front();
        start   <= 1'b1;
        n_sent  <= n_sent + 1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Check results, then record newly accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (want_q.size() == 0) begin
          flag_mismatch("unexpected result index", 64'(tile_index_o), '0);
        end else begin
          want = want_q.pop_front();
          if (tile_index_o !== want.index)
            flag_mismatch("tile_index", 64'(tile_index_o), 64'(want.index));
          if (mirror_horizontal_o !== want.mh)
            flag_mismatch("mirror_horizontal", 64'(mirror_horizontal_o), 64'(want.mh));
          if (mirror_vertical_o !== want.mv)
            flag_mismatch("mirror_vertical", 64'(mirror_vertical_o), 64'(want.mv));
          if (is_new_o !== want.is_new)
            flag_mismatch("is_new", 64'(is_new_o), 64'(want.is_new));
          if (status_o !== want.status)
            flag_mismatch("status", 64'(status_o), 64'(want.status));
        end
      end
      if (start && !busy) begin
        predict_tile(drv_req, pred);
        want_q.push_back(pred);
        n_taken++;
      end
    end
  end

  // Bound the run
  initial begin
    while (cyc_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cyc_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // Build the request list, release reset, wait for the last result
  initial begin : stim
    logic [PLANE_W-1:0] ta0, ta1, ts0, ts1, a, b, va, vb;
    logic [2*PLANE_W-1:0] hist[$];
    logic [2*PLANE_W-1:0] old;
    int run_no, run_len, sel, fresh_pct;
    bit long_run;
    logic run;

    ta0 = 64'h0123_4567_89AB_CDEF;
    ta1 = 64'h1F2E_3D4C_5B6A_7980;
    ts0 = 64'h8142_2418_FF00_C33C;
    ts1 = 64'h1818_3C3C_7E7E_FF00;

    // Extremes, all four orientations, symmetric tiles, run starts
    queue_tile('0, '0, 1'b0, 1'b0);
    queue_tile('1, '1, 1'b0, 1'b0);
    queue_tile('1, '0, 1'b0, 1'b0);
    queue_tile('0, '1, 1'b0, 1'b0);
    queue_tile(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0080, 1'b0, 1'b0);
    queue_tile(ta0, ta1, 1'b0, 1'b0);
    queue_tile(turn_plane(ta0, 1'b1, 1'b0), turn_plane(ta1, 1'b1, 1'b0), 1'b0, 1'b0);
    queue_tile(turn_plane(ta0, 1'b0, 1'b1), turn_plane(ta1, 1'b0, 1'b1), 1'b0, 1'b0);
    queue_tile(turn_plane(ta0, 1'b1, 1'b1), turn_plane(ta1, 1'b1, 1'b1), 1'b0, 1'b0);
    queue_tile(ta0, ta1, 1'b0, 1'b0);
    queue_tile(ts0, ts1, 1'b0, 1'b0);
    queue_tile(turn_plane(ts0, 1'b1, 1'b0), turn_plane(ts1, 1'b1, 1'b0), 1'b0, 1'b0);
    queue_tile(turn_plane(ts0, 1'b0, 1'b1), turn_plane(ts1, 1'b0, 1'b1), 1'b0, 1'b0);
    queue_tile(ta1, ta0, 1'b0, 1'b0);
    queue_tile(turn_plane(ta0, 1'b1, 1'b0), ta1, 1'b0, 1'b0);
    queue_tile(64'h0100_0000_0000_0080, 64'h8000_0000_0000_0000, 1'b0, 1'b0);
    queue_tile({$urandom, $urandom}, {$urandom, $urandom}, 1'b1, 1'b1);
    queue_tile(ta0, ta1, 1'b0, 1'b0);
    queue_tile(turn_plane(ta0, 1'b1, 1'b1), turn_plane(ta1, 1'b1, 1'b1), 1'b0, 1'b0);
    queue_tile('0, '0, 1'b0, 1'b0);
    queue_tile('0, '0, 1'b1, 1'b0);
    queue_tile('0, '0, 1'b1, 1'b0);

    // Random runs: mostly well-formed, some long enough to fill the table
    run_no = 0;
    while (req_q.size() < RAND_ITEMS + 22) begin
      long_run = (run_no == 1 || run_no == 4 || $urandom_range(99) < 15);
      run_len = long_run ? $urandom_range(320, 270) : $urandom_range(60, 3);
      hist.delete();
      for (int k = 0; k < run_len; k++) begin
        run = (k == 0) ? ($urandom_range(99) < 95) : ($urandom_range(99) < 3);
        fresh_pct = long_run ? ((k < TBL_DEPTH) ? 97 : 50) : 35;
        sel = $urandom_range(99);
        if (hist.size() == 0 || sel < fresh_pct) begin
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
        end else if (sel < 80) begin
          old = hist[$urandom_range(hist.size() - 1)];
          a = turn_plane(old[PLANE_W-1:0], 1'($urandom_range(1)), 1'($urandom_range(1)));
          b = turn_plane(old[2*PLANE_W-1:PLANE_W], 1'($urandom_range(1)),
                         1'($urandom_range(1)));
        end else if (sel < 92) begin
          // Mirror-symmetric rows, sometimes also symmetric top to bottom
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
          a = (a & ~M_NIB) | (turn_plane(a, 1'b1, 1'b0) & M_NIB);
          b = (b & ~M_NIB) | (turn_plane(b, 1'b1, 1'b0) & M_NIB);
          if ($urandom_range(1) != 0) begin
            va = turn_plane(a, 1'b0, 1'b1);
            vb = turn_plane(b, 1'b0, 1'b1);
            a = {a[63:32], va[31:0]};
            b = {b[63:32], vb[31:0]};
          end
        end else begin
          // Sparse tiles collide often under mirroring
          a = 64'd1 << $urandom_range(63);
          b = $urandom_range(1) ? '0 : (64'd1 << $urandom_range(63));
        end
        hist.push_back({b, a});
        queue_tile(a, b, run, (k == 0) && ($urandom_range(9) == 0));
      end
      run_no++;
    end
    n_planned = req_q.size();

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || n_taken != n_sent || want_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ tile_dedup_with_flips.f @@
+incdir+hdl
hdl/tdf_pkg.sv
hdl/tdf_ram.sv
hdl/tdf_ctrl.sv
hdl/tdf_dp.sv
hdl/tile_dedup_with_flips.sv
tb/sv/tile_dedup_with_flips_tb.sv
